/* hdl/bw_pkg.sv */
// Shared widths, constants and payload types of the barycentric weight block.
package bw_pkg;

   localparam int COORD_WIDTH      = 16;
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int OUT_WIDTH        = 24;

   // Edge component, product, determinant and magnitude widths.
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int DET_W  = PROD_W + 1;
   localparam int MAG_W  = DET_W - 1;

   // Scaled numerator, one quotient bit per divider cell.
   localparam int NUM_W  = MAG_W + WEIGHT_FRAC_BITS;
   localparam int REM_W  = MAG_W + 1;
   localparam int QS_W   = NUM_W + 2;
   localparam int WC_W   = QS_W + 2;

   localparam int REQ_W  = 8 * COORD_WIDTH;
   localparam int RSP_W  = 3 * OUT_WIDTH;

   localparam int ONE_WEIGHT = 1 << WEIGHT_FRAC_BITS;

   // Input item, last field in the lowest bits.
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] vertex_c_y;
      logic signed [COORD_WIDTH-1:0] vertex_c_x;
      logic signed [COORD_WIDTH-1:0] vertex_b_y;
      logic signed [COORD_WIDTH-1:0] vertex_b_x;
      logic signed [COORD_WIDTH-1:0] vertex_a_y;
      logic signed [COORD_WIDTH-1:0] vertex_a_x;
   } bw_req_type;

   // One division lane: partial remainder, numerator bits shifting out at the
   // top while quotient bits shift in at the bottom, and the result sign.
   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [NUM_W-1:0] nq;
      logic             neg;
   } bw_lane_type;

   typedef struct packed {
      logic             degen;
      logic [MAG_W-1:0] den;
      bw_lane_type      lane_a;
      bw_lane_type      lane_b;
   } bw_div_type;

endpackage

/* hdl/bw_front.sv */
// Edge vectors, products, determinants and divider operand set-up.
module bw_front
   import bw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       up_valid,
   output logic       up_ready,
   input  bw_req_type up_data,
   output logic       dn_valid,
   input  logic       dn_ready,
   output bw_div_type dn_data
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   logic signed [DIFF_W-1:0] e0x_ff, e0y_ff, e1x_ff, e1y_ff, epx_ff, epy_ff;
   logic signed [DIFF_W-1:0] e0x_in, e0y_in, e1x_in, e1y_in, epx_in, epy_in;

   logic signed [PROD_W-1:0] pd0_ff, pd1_ff, pa0_ff, pa1_ff, pb0_ff, pb1_ff;
   logic signed [PROD_W-1:0] pd0_in, pd1_in, pa0_in, pa1_in, pb0_in, pb1_in;

   logic signed [DET_W-1:0] det_ff, sa_ff, sb_ff;
   logic signed [DET_W-1:0] det_in, sa_in, sb_in;

   logic [MAG_W-1:0] det_mag, sa_mag, sb_mag;
   logic             degen;
   bw_div_type       div_ff, div_in;

   assign s4_ready = !s4_valid_ff || dn_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign up_ready = s1_ready;
   assign dn_valid = s4_valid_ff;
   assign dn_data  = div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= up_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   // Edges relative to the reference vertex.
   always_comb begin
      e0x_in = DIFF_W'(up_data.vertex_a_x) - DIFF_W'(up_data.vertex_c_x);
      e0y_in = DIFF_W'(up_data.vertex_a_y) - DIFF_W'(up_data.vertex_c_y);
      e1x_in = DIFF_W'(up_data.vertex_b_x) - DIFF_W'(up_data.vertex_c_x);
      e1y_in = DIFF_W'(up_data.vertex_b_y) - DIFF_W'(up_data.vertex_c_y);
      epx_in = DIFF_W'(up_data.point_x)    - DIFF_W'(up_data.vertex_c_x);
      epy_in = DIFF_W'(up_data.point_y)    - DIFF_W'(up_data.vertex_c_y);
   end

   always_comb begin
      pd0_in = e0x_ff * e1y_ff;
      pd1_in = e1x_ff * e0y_ff;
      pa0_in = epx_ff * e1y_ff;
      pa1_in = e1x_ff * epy_ff;
      pb0_in = e0x_ff * epy_ff;
      pb1_in = epx_ff * e0y_ff;
   end

   always_comb begin
      det_in = DET_W'(pd0_ff) - DET_W'(pd1_ff);
      sa_in  = DET_W'(pa0_ff) - DET_W'(pa1_ff);
      sb_in  = DET_W'(pb0_ff) - DET_W'(pb1_ff);
   end

   // Split into sign and magnitude; scale numerators unless degenerate.
   always_comb begin
      det_mag = det_ff[DET_W-1] ? MAG_W'(-det_ff) : MAG_W'(det_ff);
      sa_mag  = sa_ff[DET_W-1]  ? MAG_W'(-sa_ff)  : MAG_W'(sa_ff);
      sb_mag  = sb_ff[DET_W-1]  ? MAG_W'(-sb_ff)  : MAG_W'(sb_ff);
      degen   = (det_ff == '0);

      div_in.degen      = degen;
      div_in.den        = det_mag;
      div_in.lane_a.rem = '0;
      div_in.lane_b.rem = '0;
      div_in.lane_a.neg = sa_ff[DET_W-1] ^ det_ff[DET_W-1];
      div_in.lane_b.neg = sb_ff[DET_W-1] ^ det_ff[DET_W-1];
      if (degen) begin
         div_in.lane_a.nq = NUM_W'(sa_mag);
         div_in.lane_b.nq = NUM_W'(sb_mag);
      end else begin
         div_in.lane_a.nq = {sa_mag, {WEIGHT_FRAC_BITS{1'b0}}};
         div_in.lane_b.nq = {sb_mag, {WEIGHT_FRAC_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         e0x_ff <= e0x_in;
         e0y_ff <= e0y_in;
         e1x_ff <= e1x_in;
         e1y_ff <= e1y_in;
         epx_ff <= epx_in;
         epy_ff <= epy_in;
      end
      if (s2_ready) begin
         pd0_ff <= pd0_in;
         pd1_ff <= pd1_in;
         pa0_ff <= pa0_in;
         pa1_ff <= pa1_in;
         pb0_ff <= pb0_in;
         pb1_ff <= pb1_in;
      end
      if (s3_ready) begin
         det_ff <= det_in;
         sa_ff  <= sa_in;
         sb_ff  <= sb_in;
      end
      if (s4_ready) begin
         div_ff <= div_in;
      end
   end

endmodule

/* hdl/bw_div_cell.sv */
// One restoring-division cell: one quotient bit for each of the two lanes.
module bw_div_cell
   import bw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       up_valid,
   output logic       up_ready,
   input  bw_div_type up_data,
   output logic       dn_valid,
   input  logic       dn_ready,
   output bw_div_type dn_data
);

   logic       valid_ff;
   bw_div_type data_ff, data_in;

   function automatic bw_lane_type div_step(bw_lane_type l, logic [MAG_W-1:0] den,
                                             logic degen);
      logic [REM_W-1:0] trial;
      logic             fits;
      bw_lane_type      r;
      trial = {l.rem, l.nq[NUM_W-1]};
      fits  = (trial >= REM_W'(den));
      r     = l;
      if (!degen) begin
         r.rem = fits ? MAG_W'(trial - REM_W'(den)) : MAG_W'(trial);
         r.nq  = {l.nq[NUM_W-2:0], fits};
      end
      return r;
   endfunction

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      data_in        = up_data;
      data_in.lane_a = div_step(up_data.lane_a, up_data.den, up_data.degen);
      data_in.lane_b = div_step(up_data.lane_b, up_data.den, up_data.degen);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (dn_valid && !dn_data.degen) |->
         (dn_data.lane_a.rem < dn_data.den && dn_data.lane_b.rem < dn_data.den))
      else $error("partial remainder not below divisor");

   a_degen_holds: assert property (@(posedge clock) disable iff (reset)
      (up_valid && up_ready && up_data.degen) |=>
         (dn_data.lane_a.nq == $past(up_data.lane_a.nq) &&
          dn_data.lane_b.nq == $past(up_data.lane_b.nq)))
      else $error("degenerate item altered by divider cell");

endmodule

/* hdl/bw_back.sv */
// Rounding, sign restore, third weight and saturation into the output register.
module bw_back
   import bw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  bw_div_type           up_data,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output logic [OUT_WIDTH-1:0] weight_a,
   output logic [OUT_WIDTH-1:0] weight_b,
   output logic [OUT_WIDTH-1:0] weight_c,
   output logic                 degenerate
);

   logic s1_valid_ff, s2_valid_ff;
   logic s1_ready, s2_ready;

   logic signed [QS_W-1:0] wa_ff, wb_ff, wa_in, wb_in;
   logic                   degen_ff;
   logic signed [WC_W-1:0] wc_full;

   logic [OUT_WIDTH-1:0] wa_out_ff, wb_out_ff, wc_out_ff;
   logic [OUT_WIDTH-1:0] wa_out_in, wb_out_in, wc_out_in;
   logic                 degen_out_ff;

   localparam logic signed [WC_W-1:0] SAT_HI = WC_W'((2 ** (OUT_WIDTH - 1)) - 1);
   localparam logic signed [WC_W-1:0] SAT_LO = -SAT_HI - WC_W'(1);

   function automatic logic signed [QS_W-1:0] finish(bw_lane_type l,
                                                      logic [MAG_W-1:0] den,
                                                      logic degen);
      logic             round_up;
      logic [NUM_W:0]   q;
      logic [QS_W-1:0]  qe;
      round_up = !degen && ({l.rem, 1'b0} >= REM_W'(den));
      q        = {1'b0, l.nq} + (NUM_W + 1)'(round_up);
      qe       = QS_W'(q);
      return l.neg ? -qe : qe;
   endfunction

   function automatic logic [OUT_WIDTH-1:0] sat(logic signed [WC_W-1:0] v);
      logic signed [WC_W-1:0] c;
      c = v;
      if (v > SAT_HI) c = SAT_HI;
      if (v < SAT_LO) c = SAT_LO;
      return OUT_WIDTH'(c);
   endfunction

   assign s2_ready   = !s2_valid_ff || dn_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign up_ready   = s1_ready;
   assign dn_valid   = s2_valid_ff;
   assign weight_a   = wa_out_ff;
   assign weight_b   = wb_out_ff;
   assign weight_c   = wc_out_ff;
   assign degenerate = degen_out_ff;

   always_comb begin
      wa_in = finish(up_data.lane_a, up_data.den, up_data.degen);
      wb_in = finish(up_data.lane_b, up_data.den, up_data.degen);
   end

   // Weight C from the unclamped weights, then clamp all three.
   always_comb begin
      wc_full   = WC_W'(ONE_WEIGHT) - WC_W'(wa_ff) - WC_W'(wb_ff);
      wa_out_in = sat(WC_W'(wa_ff));
      wb_out_in = sat(WC_W'(wb_ff));
      wc_out_in = sat(wc_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= up_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         wa_ff    <= wa_in;
         wb_ff    <= wb_in;
         degen_ff <= up_data.degen;
      end
      if (s2_ready) begin
         wa_out_ff    <= wa_out_in;
         wb_out_ff    <= wb_out_in;
         wc_out_ff    <= wc_out_in;
         degen_out_ff <= degen_ff;
      end
   end

endmodule

/* hdl/barycentric_weights_2d.sv */
// Top level of the 2D barycentric weight pipeline.
//
// Usage: each req item carries a triangle A, B, C and a query point P as
// signed Q12.4 coordinates; each accepted item yields exactly one rsp item
// with the weights of A, B and C in signed Q8.16, clamped to 24 bits, and a
// degenerate flag on rsp_tuser when the triangle has zero area. For a
// degenerate triangle the A and B weights carry the undivided integer
// sub-determinants, clamped, and C is one minus those two.
// Pipeline: 4 set-up stages, 34 + 16 = 50 divider cells of one quotient bit
// each, and 2 finishing stages. Throughput: one item per cycle while
// rsp_tready is high; the chain of divider cells, one quotient bit per cell,
// lets a new item enter behind the last one every cycle unless rsp stalls.
// Every stage has its own valid bit and moves on when the stage ahead is
// empty or moving, so a stalled rsp side only fills bubbles; req_tready
// drops once every stage holds an item. The result sits in the output
// register until taken.
// Reset: synchronous, active high; clears all valid bits, no item in flight.
module barycentric_weights_2d
   import bw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
   // point_x, point_y (16 bits each, lowest first)
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // weight_a, weight_b, weight_c (24 bits each, lowest first)
   output logic [RSP_W-1:0] rsp_tdata,
   // degenerate
   output logic             rsp_tuser
);

   // chain[0] is the set-up output, chain[NUM_W] feeds the finishing stages.
   logic       chain_valid [0:NUM_W];
   logic       chain_ready [0:NUM_W];
   bw_div_type chain_data  [0:NUM_W];

   logic [OUT_WIDTH-1:0] weight_a, weight_b, weight_c;

   bw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .up_data  (bw_req_type'(req_tdata)),
      .dn_valid (chain_valid[0]),
      .dn_ready (chain_ready[0]),
      .dn_data  (chain_data[0])
   );

   // One cell per quotient bit, most significant first.
   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      bw_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[i]),
         .up_ready (chain_ready[i]),
         .up_data  (chain_data[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_ready (chain_ready[i+1]),
         .dn_data  (chain_data[i+1])
      );
   end

   bw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (chain_valid[NUM_W]),
      .up_ready   (chain_ready[NUM_W]),
      .up_data    (chain_data[NUM_W]),
      .dn_valid   (rsp_tvalid),
      .dn_ready   (rsp_tready),
      .weight_a   (weight_a),
      .weight_b   (weight_b),
      .weight_c   (weight_c),
      .degenerate (rsp_tuser)
   );

   // Pack the weights, weight A in the lowest bits.
   assign rsp_tdata = {weight_c, weight_b, weight_a};

   // With no result waiting every stage can move, so the input must be open.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req side blocked with output register empty");

endmodule
